// File: rtl/mvt_pkg.sv
`default_nettype none

package mvt_pkg;

  // Vector length and matrix size (the matrix is VEC_LEN x VEC_LEN).
  localparam int VEC_LEN = 4;

  // Configuration register file.
  localparam int NUM_REGS        = 8;
  localparam int REG_WIDTH       = 64;
  localparam int REG_SEL_WIDTH   = $clog2(NUM_REGS);
  localparam int CFG_INDEX_WIDTH = 4;
  localparam int HALF_WIDTH      = 32;

  // Width of the fields on the ports.
  localparam int PORT_WIDTH = 32;

  // Reset contents give the identity matrix in Q16.16.
  localparam logic [REG_WIDTH-1:0] REG_RESET [NUM_REGS] = '{
    64'h0000_0000_0001_0000,
    64'h0000_0000_0000_0000,
    64'h0001_0000_0000_0000,
    64'h0000_0000_0000_0000,
    64'h0000_0000_0000_0000,
    64'h0000_0000_0001_0000,
    64'h0000_0000_0000_0000,
    64'h0001_0000_0000_0000
  };

  typedef struct packed {
    logic signed [PORT_WIDTH-1:0] in_x;
    logic signed [PORT_WIDTH-1:0] in_y;
    logic signed [PORT_WIDTH-1:0] in_z;
    logic signed [PORT_WIDTH-1:0] in_w;
  } in_item_t;

  typedef struct packed {
    logic signed [PORT_WIDTH-1:0] out_x;
    logic signed [PORT_WIDTH-1:0] out_y;
    logic signed [PORT_WIDTH-1:0] out_z;
    logic signed [PORT_WIDTH-1:0] out_w;
    logic                         saturated;
  } out_item_t;

endpackage

`default_nettype wire

// File: rtl/mvt_cell.sv
`default_nettype none

module mvt_cell import mvt_pkg::*; #(
  parameter int DW = 32,
  parameter int SW = 66,
  parameter int K  = 0
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [DW-1:0] in_vec [VEC_LEN],
  input  logic signed [SW-1:0] in_sum [VEC_LEN],
  input  logic signed [DW-1:0] col    [VEC_LEN],
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [DW-1:0] out_vec [VEC_LEN],
  output logic signed [SW-1:0] out_sum [VEC_LEN]
);

  // Product stage.
  logic                   p_valid;
  logic signed [DW-1:0]   p_vec  [VEC_LEN];
  logic signed [SW-1:0]   p_sum  [VEC_LEN];
  logic signed [2*DW-1:0] p_prod [VEC_LEN];

  // Accumulate stage.
  logic                 s_valid;
  logic signed [DW-1:0] s_vec [VEC_LEN];
  logic signed [SW-1:0] s_sum [VEC_LEN];
  logic                 s_ready;

  assign s_ready  = !s_valid || out_ready;
  assign in_ready = !p_valid || s_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (in_ready) begin
      p_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      for (int r = 0; r < VEC_LEN; r++) begin
        p_prod[r] <= in_vec[K] * col[r];
        p_vec[r]  <= in_vec[r];
        p_sum[r]  <= in_sum[r];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (s_ready) begin
      s_valid <= p_valid;
    end
  end

  // The sum of four products always fits in SW bits, so no overflow here.
  always_ff @(posedge clk) begin
    if (s_ready && p_valid) begin
      for (int r = 0; r < VEC_LEN; r++) begin
        s_sum[r] <= p_sum[r] + SW'(p_prod[r]);
        s_vec[r] <= p_vec[r];
      end
    end
  end

  assign out_valid = s_valid;
  assign out_vec   = s_vec;
  assign out_sum   = s_sum;

endmodule

`default_nettype wire

// File: rtl/mvt_round_sat.sv
`default_nettype none

module mvt_round_sat import mvt_pkg::*; #(
  parameter int DW = 32,
  parameter int FB = 16,
  parameter int SW = 66
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [SW-1:0] in_sum [VEC_LEN],
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_item
);

  localparam logic signed [SW-1:0] HALF = SW'(1) <<< (FB - 1);
  localparam logic signed [DW-1:0] MAXV = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] MINV = {1'b1, {(DW-1){1'b0}}};

  logic signed [SW-1:0] rnd [VEC_LEN];
  logic signed [SW-1:0] quo [VEC_LEN];
  logic signed [DW-1:0] res [VEC_LEN];
  logic [VEC_LEN-1:0]   clip;
  out_item_t            item_next;

  // Round half up, then clip when the bits above the sign do not agree.
  always_comb begin
    for (int r = 0; r < VEC_LEN; r++) begin
      rnd[r] = in_sum[r] + HALF;
      quo[r] = rnd[r] >>> FB;
      clip[r] = !((&quo[r][SW-1:DW-1]) || !(|quo[r][SW-1:DW-1]));
      if (clip[r]) begin
        res[r] = quo[r][SW-1] ? MINV : MAXV;
      end else begin
        res[r] = quo[r][DW-1:0];
      end
    end
    item_next.out_x     = PORT_WIDTH'(res[0]);
    item_next.out_y     = PORT_WIDTH'(res[1]);
    item_next.out_z     = PORT_WIDTH'(res[2]);
    item_next.out_w     = PORT_WIDTH'(res[3]);
    item_next.saturated = |clip;
  end

  assign in_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_item <= item_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/matrix_vector_transform_4x4_core.sv
// Throughput: one item per cycle while out_stall is low; nine registered stages hold up
// to nine items in flight: each cell's product and sum stages and the output register.
// Each of the four cells spends one stage on its multiplies and one on its adds.
// Reset (rst, synchronous, active high) empties the pipeline and loads the identity matrix.
`default_nettype none

module matrix_vector_transform_4x4_core import mvt_pkg::*; #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  in_item_t                   in_item,
  output logic                       out_valid,
  input  logic                       out_stall,
  output out_item_t                  out_item,
  input  logic                       cfg_we,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [REG_WIDTH-1:0]       cfg_data
);

  // The running sums carry four full products, which needs two bits of growth.
  localparam int SW = 2 * DATA_WIDTH + 2;

  // Matrix registers. Register i holds element 2i in its low half and element 2i+1
  // in its high half; each element is the low DATA_WIDTH bits of its half, signed.
  // The matrix is column-major, so cell k takes elements 4k through 4k+3.
  logic [REG_WIDTH-1:0] mat_reg [NUM_REGS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        mat_reg[i] <= REG_RESET[i];
      end
    end else if (cfg_we && (cfg_index < CFG_INDEX_WIDTH'(NUM_REGS))) begin
      // Writes to an index past the last register are dropped.
      mat_reg[cfg_index[REG_SEL_WIDTH-1:0]] <= cfg_data;
    end
  end

  // Chain wiring. Stage k of each array feeds cell k; the last sum goes to rounding.
  logic signed [DATA_WIDTH-1:0] col   [VEC_LEN][VEC_LEN];
  logic signed [DATA_WIDTH-1:0] vec_c [VEC_LEN][VEC_LEN];
  logic signed [SW-1:0]         sum_c [VEC_LEN+1][VEC_LEN];
  logic [VEC_LEN:0]             valid_c;
  logic [VEC_LEN:0]             ready_c;

  for (genvar k = 0; k < VEC_LEN; k++) begin : g_col
    for (genvar r = 0; r < VEC_LEN; r++) begin : g_row
      assign col[k][r] =
        signed'(mat_reg[(k * VEC_LEN + r) / 2][HALF_WIDTH * (r % 2) +: DATA_WIDTH]);
    end
  end

  // The input vector enters the first cell with zero partial sums.
  assign vec_c[0][0] = signed'(in_item.in_x[DATA_WIDTH-1:0]);
  assign vec_c[0][1] = signed'(in_item.in_y[DATA_WIDTH-1:0]);
  assign vec_c[0][2] = signed'(in_item.in_z[DATA_WIDTH-1:0]);
  assign vec_c[0][3] = signed'(in_item.in_w[DATA_WIDTH-1:0]);

  for (genvar r = 0; r < VEC_LEN; r++) begin : g_zero
    assign sum_c[0][r] = '0;
  end

  assign valid_c[0] = in_valid;
  assign in_stall   = !ready_c[0];

  // Cell k multiplies vector element k by matrix column k and adds the four
  // products onto the sums handed over by cell k-1. Each cell stalls only when
  // its own registers are full and the next cell cannot take them.
  for (genvar k = 0; k < VEC_LEN; k++) begin : g_cell
    if (k < VEC_LEN - 1) begin : g_mid
      mvt_cell #(
        .DW (DATA_WIDTH),
        .SW (SW),
        .K  (k)
      ) u_cell (
        .clk       (clk),
        .rst       (rst),
        .in_valid  (valid_c[k]),
        .in_ready  (ready_c[k]),
        .in_vec    (vec_c[k]),
        .in_sum    (sum_c[k]),
        .col       (col[k]),
        .out_valid (valid_c[k+1]),
        .out_ready (ready_c[k+1]),
        .out_vec   (vec_c[k+1]),
        .out_sum   (sum_c[k+1])
      );
    end else begin : g_last
      // The vector is no longer needed past the last cell.
      mvt_cell #(
        .DW (DATA_WIDTH),
        .SW (SW),
        .K  (k)
      ) u_cell (
        .clk       (clk),
        .rst       (rst),
        .in_valid  (valid_c[k]),
        .in_ready  (ready_c[k]),
        .in_vec    (vec_c[k]),
        .in_sum    (sum_c[k]),
        .col       (col[k]),
        .out_valid (valid_c[k+1]),
        .out_ready (ready_c[k+1]),
        .out_vec   (),
        .out_sum   (sum_c[k+1])
      );
    end
  end

  // Rounding to nearest (ties up), clipping and the output register. A result
  // that waits here does not block the cells behind it from filling up.
  mvt_round_sat #(
    .DW (DATA_WIDTH),
    .FB (FRAC_BITS),
    .SW (SW)
  ) u_round_sat (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (valid_c[VEC_LEN]),
    .in_ready  (ready_c[VEC_LEN]),
    .in_sum    (sum_c[VEC_LEN]),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

// File: rtl/mvt_checker.sv
`default_nettype none

module mvt_checker import mvt_pkg::*; #(
  parameter int DATA_WIDTH = 32
) (
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_item
);

  localparam int CAPACITY = 2 * VEC_LEN + 1;
  localparam logic signed [PORT_WIDTH-1:0] MAXV =
    PORT_WIDTH'({1'b0, {(DATA_WIDTH-1){1'b1}}});
  localparam logic signed [PORT_WIDTH-1:0] MINV =
    PORT_WIDTH'(signed'({1'b1, {(DATA_WIDTH-1){1'b0}}}));

  logic       in_acc;
  logic       out_acc;
  logic [4:0] pending;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  // Items accepted but not yet delivered.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 5'(in_acc) - 5'(out_acc);
    end
  end

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (pending != '0))
    else $error("result shown without an item in flight");

  a_capacity: assert property (@(posedge clk) disable iff (rst)
    pending <= 5'(CAPACITY))
    else $error("more items in flight than pipeline stages");

  a_sat_bound: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.saturated) |->
      (out_item.out_x == MAXV || out_item.out_x == MINV ||
       out_item.out_y == MAXV || out_item.out_y == MINV ||
       out_item.out_z == MAXV || out_item.out_z == MINV ||
       out_item.out_w == MAXV || out_item.out_w == MINV))
    else $error("saturation flag without a clipped component");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_item)))
    else $error("stalled result changed");

endmodule

bind matrix_vector_transform_4x4_core mvt_checker #(
  .DATA_WIDTH (DATA_WIDTH)
) u_mvt_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

`default_nettype wire
